[design/dq_pkg.sv]
// Shared types, codes and default constants of the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int WIDE_W   = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_REAR  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_REAR   = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic read;
        logic load;
    } dq_cmd_t;

endpackage

[design/dq_ctrl.sv]
// Controller state machine that sequences each transaction through the datapath.
module dq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_cmd_t cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            dq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = dq_pkg::ST_READ;
            end
            dq_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = dq_pkg::ST_DONE;
            end
            dq_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[design/dq_datapath.sv]
// Datapath with the ring memory, the head and count registers and the result registers.
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dq_pkg::dq_cmd_t                    cmd,
    input  logic [dq_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [dq_pkg::VALUE_W-1:0]  s_value,
    output logic [dq_pkg::STATUS_W-1:0]        m_status,
    output logic                               m_is_empty,
    output logic [dq_pkg::COUNT_W-1:0]         m_entry_count,
    output logic signed [dq_pkg::VALUE_W-1:0]  m_front_value,
    output logic signed [dq_pkg::VALUE_W-1:0]  m_rear_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_POS   = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [SW-1:0] WRAP_SUM   = SW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [dq_pkg::KIND_W-1:0]   kind_reg;
    logic [dq_pkg::VALUE_W-1:0]  value_reg;
    logic [AW-1:0]               head_reg;
    logic [AW-1:0]               head_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    dq_pkg::status_t             status_reg;
    dq_pkg::status_t             status_next;
    logic [DATA_WIDTH-1:0]       rd_front_reg;
    logic [DATA_WIDTH-1:0]       rd_rear_reg;
    logic [dq_pkg::STATUS_W-1:0] out_status_reg;
    logic                        out_empty_reg;
    logic [dq_pkg::COUNT_W-1:0]  out_count_reg;
    logic [dq_pkg::VALUE_W-1:0]  out_front_reg;
    logic [dq_pkg::VALUE_W-1:0]  out_rear_reg;

    logic                        full;
    logic                        empty;
    logic [AW-1:0]               head_dec;
    logic [AW-1:0]               head_inc;
    logic [SW-1:0]               tail_sum;
    logic [AW-1:0]               tail_pos;
    logic [CW-1:0]               count_m1;
    logic [SW-1:0]               rear_sum;
    logic [AW-1:0]               rear_pos;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [dq_pkg::WIDE_W-1:0]   value_wide;
    logic [dq_pkg::WIDE_W-1:0]   front_wide;
    logic [dq_pkg::WIDE_W-1:0]   rear_wide;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_pos = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
    assign count_m1 = count_reg - 1'b1;
    assign rear_sum = SW'(head_reg) + SW'(count_m1);
    assign rear_pos = (rear_sum >= WRAP_SUM) ? AW'(rear_sum - WRAP_SUM) : AW'(rear_sum);

    assign value_wide = dq_pkg::WIDE_W'(value_reg);
    assign front_wide = dq_pkg::WIDE_W'(rd_front_reg);
    assign rear_wide  = dq_pkg::WIDE_W'(rd_rear_reg);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_pos;
        if (cmd.execute) begin
            status_next = dq_pkg::STATUS_OK;
            case (kind_reg)
                dq_pkg::KIND_PUSH_FRONT: begin
                    if (full) begin
                        status_next = dq_pkg::STATUS_OVERFLOW;
                    end else begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::KIND_PUSH_REAR: begin
                    if (full) begin
                        status_next = dq_pkg::STATUS_OVERFLOW;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_pos;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::KIND_POP_FRONT: begin
                    if (empty) begin
                        status_next = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        head_next  = head_inc;
                        count_next = count_m1;
                    end
                end
                dq_pkg::KIND_POP_REAR: begin
                    if (empty) begin
                        status_next = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        count_next = count_m1;
                    end
                end
                default: begin
                    status_next = dq_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_wide[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_front_reg <= mem[head_reg];
            rd_rear_reg  <= mem[rear_pos];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= status_reg;
            out_empty_reg  <= empty;
            out_count_reg  <= dq_pkg::COUNT_W'(count_reg);
            out_front_reg  <= empty ? '0 : front_wide[dq_pkg::VALUE_W-1:0];
            out_rear_reg   <= empty ? '0 : rear_wide[dq_pkg::VALUE_W-1:0];
        end
    end

    assign m_status      = out_status_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_entry_count = out_count_reg;
    assign m_front_value = out_front_reg;
    assign m_rear_value  = out_rear_reg;

endmodule

[design/double_ended_queue.sv]
// Top level of the bounded double-ended queue with its checks.
//
// This block is a bounded deque of DEPTH words kept in a ring memory. Each input
// transaction pushes at the front or rear, pops the front or rear, or only queries, and
// yields one result transaction with a status, the entry count, an empty flag and the
// front and rear words after the operation (zero when empty). A push onto a full deque
// reports overflow and a pop from an empty deque reports underflow, both leaving the
// contents unchanged. One transaction is handled at a time: after acceptance the
// controller passes an execute state that updates the ring memory and pointers, a read
// state for the registered read of the front and rear words and a done state that loads
// the result register. The next transaction is accepted while a result still waits in
// the result register; its own result is loaded once that register has been emptied.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dq_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [dq_pkg::VALUE_W-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dq_pkg::STATUS_W-1:0]        m_status,
    output logic                               m_is_empty,
    output logic [dq_pkg::COUNT_W-1:0]         m_entry_count,
    output logic signed [dq_pkg::VALUE_W-1:0]  m_front_value,
    output logic signed [dq_pkg::VALUE_W-1:0]  m_rear_value
);

    dq_pkg::dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_is_empty    (m_is_empty),
        .m_entry_count (m_entry_count),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value)
    );

`ifndef SYNTHESIS
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |->
            m_entry_count == '0 && m_front_value == '0 && m_rear_value == '0)
        else $error("Empty result carries a nonzero count or word.");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == dq_pkg::STATUS_UNDERFLOW |-> m_is_empty)
        else $error("Underflow reported on a nonempty deque.");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == dq_pkg::STATUS_OVERFLOW |->
            !m_is_empty && m_entry_count == dq_pkg::COUNT_W'(DEPTH))
        else $error("Overflow reported on a deque that is not full.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while a transaction is in progress.");
`endif

endmodule
